/* hw/rtl/dsr_pkg.sv */
// dsr_pkg: shared widths, codes, reset values and types of the deferred slot recycler.
// Used by dsr_level_fifo and deferred_slot_recycler_core; depends on nothing.
`default_nettype none

package dsr_pkg;

  // default sizing, handed to the top level as parameter defaults
  localparam int unsigned MaxLevelsDef = 16;
  localparam int unsigned MaxSlotsDef  = 32;

  // fixed field widths
  localparam int unsigned OpcodeW    = 2;
  localparam int unsigned LevelW     = 4;
  localparam int unsigned SlotW      = 5;
  localparam int unsigned OffsetW    = 24;
  localparam int unsigned CountW     = 8;
  localparam int unsigned StampW     = 32;
  localparam int unsigned KindW      = 2;
  localparam int unsigned SlotsCfgW  = 6;
  localparam int unsigned LevelsCfgW = 5;
  localparam int unsigned DelayCfgW  = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 6;

  // register reset values
  localparam logic [SlotsCfgW-1:0]  SlotsRst  = 6'd32;
  localparam logic [LevelsCfgW-1:0] LevelsRst = 5'd16;
  localparam logic [DelayCfgW-1:0]  DelayRst  = 4'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SLOTS_PER_LEVEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_COUNT     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RECLAIM_DELAY   = 2'd2;

  typedef enum logic [OpcodeW-1:0] {
    OP_TICK   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_RETIRE = 2'd2
  } opcode_e;

  typedef enum logic [KindW-1:0] {
    KIND_GRANT     = 2'd0,
    KIND_FREED     = 2'd1,
    KIND_RET_OK    = 2'd2,
    KIND_RET_DROP  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_DRAIN_RD,
    ST_DRAIN_CHK,
    ST_GRANT_RD,
    ST_GRANT
  } state_e;

  // one retired FIFO entry
  typedef struct packed {
    logic [SlotW-1:0]   slot;
    logic [OffsetW-1:0] offset;
    logic [CountW-1:0]  count;
    logic [StampW-1:0]  stamp;
  } ret_entry_t;

  localparam int unsigned RetEntryW = $bits(ret_entry_t);

  // occupancy of the addressed level's queue
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/dsr_level_fifo.sv */
// dsr_level_fifo: one FIFO per level, all sharing a single synchronous memory.
// Per-level head and fill live in flops; the read port is registered, so read data shows in the cycle after the read.
// Depends on dsr_pkg.
`default_nettype none

module dsr_level_fifo import dsr_pkg::*; #(
  parameter  int unsigned MAX_LEVELS = MaxLevelsDef,
  parameter  int unsigned MAX_SLOTS  = MaxSlotsDef,
  parameter  int unsigned DATA_W     = SlotW,
  localparam int unsigned LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [LW-1:0]     level_i,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  input  wire logic              rd_i,
  input  wire logic              pop_i,
  output      logic [DATA_W-1:0] head_data_o,
  output      fifo_stat_t        stat_o
);

  localparam int unsigned HW    = $clog2(MAX_SLOTS);
  localparam int unsigned FW    = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SW    = HW + 1;
  localparam int unsigned Depth = MAX_LEVELS * MAX_SLOTS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [AW-1:0] Stride   = AW'(MAX_SLOTS);
  localparam logic [SW-1:0] SlotsSum = SW'(MAX_SLOTS);
  localparam logic [FW-1:0] SlotsFil = FW'(MAX_SLOTS);

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rd_data_q;

  logic [HW-1:0] head_q [MAX_LEVELS];
  logic [FW-1:0] fill_q [MAX_LEVELS];

  logic [HW-1:0] head;
  logic [FW-1:0] fill;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] head_inc;
  logic [HW-1:0] tail_pos;
  logic [HW-1:0] head_nxt;
  logic [AW-1:0] base_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign head = head_q[level_i];
  assign fill = fill_q[level_i];

  assign stat_o.empty = (fill == '0);
  assign stat_o.full  = (fill == SlotsFil);

  // tail = (head + fill) mod slots, the sum stays below twice the slot count
  assign tail_sum = SW'(head) + SW'(fill);
  assign tail_pos = (tail_sum >= SlotsSum) ? HW'(tail_sum - SlotsSum) : HW'(tail_sum);
  assign head_inc = SW'(head) + SW'(1);
  assign head_nxt = (head_inc == SlotsSum) ? '0 : HW'(head_inc);

  assign base_addr = AW'(level_i) * Stride;
  assign wr_addr   = base_addr + AW'(tail_pos);
  assign rd_addr   = base_addr + AW'(head);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_addr] <= push_data_i;
    end
    if (rd_i) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign head_data_o = rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      if (push_i && !pop_i) begin
        fill_q[level_i] <= fill + FW'(1);
      end else if (pop_i && !push_i) begin
        fill_q[level_i] <= fill - FW'(1);
      end
      if (pop_i) begin
        head_q[level_i] <= head_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/deferred_slot_recycler_core.sv */
// deferred_slot_recycler_core: top level of the per-level slot recycler.
// Holds config, frame counter, ring cursors, control sequencer and result register.
// Depends on dsr_pkg and dsr_level_fifo.
`default_nettype none

// Per-level pool slot recycler with delayed reclamation. Items are taken one at a
// time through a single control sequencer; the retired and ready queues sit in two
// synchronous memories with registered reads, so each queue read has its own state.
// A frame tick is done on acceptance, a retire in the retire state. An allocate
// runs drain read, grant read and grant, with a drain check after each retired entry
// read and a return to drain read for each entry drained into the ready queue; out
// of range it goes from drain read straight to grant. Each emitted result also waits
// for the result register to be taken. A new item is accepted while an earlier
// result still sits in the result register. Queue memories need no clearing after
// reset: only entries inside a queue's fill are ever read.
module deferred_slot_recycler_core import dsr_pkg::*; #(
  parameter int unsigned MAX_LEVELS = MaxLevelsDef,
  parameter int unsigned MAX_SLOTS  = MaxSlotsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i,
  // input items
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [OpcodeW-1:0]    in_opcode_i,
  input  wire logic [LevelW-1:0]     in_level_i,
  input  wire logic [SlotW-1:0]      in_pool_slot_i,
  input  wire logic [OffsetW-1:0]    in_range_offset_i,
  input  wire logic [CountW-1:0]     in_range_count_i,
  // results
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [KindW-1:0]      out_kind_o,
  output      logic [SlotW-1:0]      out_granted_slot_o,
  output      logic                  out_from_ready_o,
  output      logic [OffsetW-1:0]    out_freed_offset_o,
  output      logic [CountW-1:0]     out_freed_count_o,
  output      logic                  out_last_o
);

  localparam int unsigned LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned HW = $clog2(MAX_SLOTS);
  localparam int unsigned FW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CW = (FW > SlotsCfgW) ? FW : SlotsCfgW;

  localparam logic [LevelsCfgW-1:0] MaxLevelsCfg = LevelsCfgW'(MAX_LEVELS);
  localparam logic [CW-1:0]         MaxSlotsCmp  = CW'(MAX_SLOTS);

  // configuration registers
  logic [SlotsCfgW-1:0]  slots_q;
  logic [LevelsCfgW-1:0] levels_q;
  logic [DelayCfgW-1:0]  delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= SlotsRst;
      levels_q <= LevelsRst;
      delay_q  <= DelayRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLOTS_PER_LEVEL: slots_q  <= cfg_data_i[SlotsCfgW-1:0];
        CFG_LEVEL_COUNT:     levels_q <= cfg_data_i[LevelsCfgW-1:0];
        CFG_RECLAIM_DELAY:   delay_q  <= cfg_data_i[DelayCfgW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and item registers
  state_e state_q, state_d;
  logic   in_fire;

  logic [LevelW-1:0]  lv_q;
  logic [SlotW-1:0]   ps_q;
  logic [OffsetW-1:0] ro_q;
  logic [CountW-1:0]  rc_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lv_q <= in_level_i;
      ps_q <= in_pool_slot_i;
      ro_q <= in_range_offset_i;
      rc_q <= in_range_count_i;
    end
  end

  logic [LW-1:0]         lv_idx;
  logic [LevelsCfgW-1:0] levels_used;
  logic                  lv_ok;

  assign lv_idx      = lv_q[LW-1:0];
  assign levels_used = (levels_q > MaxLevelsCfg) ? MaxLevelsCfg : levels_q;
  assign lv_ok       = (LevelsCfgW'(lv_q) < levels_used);

  // frame counter
  logic [StampW-1:0] frame_q;
  logic              frame_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (frame_inc) begin
      frame_q <= frame_q + StampW'(1);
    end
  end

  // queues
  logic                 ret_push, ret_rd, ret_pop;
  logic                 rdy_push, rdy_rd, rdy_pop;
  ret_entry_t           ret_new;
  logic [RetEntryW-1:0] ret_head_raw;
  ret_entry_t           ret_head;
  logic [SlotW-1:0]     rdy_head;
  fifo_stat_t           ret_stat, rdy_stat;

  assign ret_new.slot   = ps_q;
  assign ret_new.offset = ro_q;
  assign ret_new.count  = rc_q;
  assign ret_new.stamp  = frame_q;
  assign ret_head       = ret_head_raw;

  dsr_level_fifo #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_SLOTS  (MAX_SLOTS),
    .DATA_W     (RetEntryW)
  ) u_retired (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .level_i     (lv_idx),
    .push_i      (ret_push),
    .push_data_i (ret_new),
    .rd_i        (ret_rd),
    .pop_i       (ret_pop),
    .head_data_o (ret_head_raw),
    .stat_o      (ret_stat)
  );

  dsr_level_fifo #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_SLOTS  (MAX_SLOTS),
    .DATA_W     (SlotW)
  ) u_ready (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .level_i     (lv_idx),
    .push_i      (rdy_push),
    .push_data_i (ret_head.slot),
    .rd_i        (rdy_rd),
    .pop_i       (rdy_pop),
    .head_data_o (rdy_head),
    .stat_o      (rdy_stat)
  );

  // ring cursors
  logic [HW-1:0]       cursor_q [MAX_LEVELS];
  logic [HW-1:0]       cur;
  logic [HW+SlotW-1:0] cur_ext;
  logic [CW-1:0]       slots_cmp;
  logic [CW-1:0]       wrap;
  logic [CW-1:0]       cur_inc;
  logic [HW-1:0]       cur_nxt;
  logic                cur_adv;

  assign cur       = cursor_q[lv_idx];
  assign cur_ext   = {{SlotW{1'b0}}, cur};
  assign slots_cmp = CW'(slots_q);
  assign wrap      = (slots_cmp == '0) ? CW'(1) :
                     (slots_cmp > MaxSlotsCmp) ? MaxSlotsCmp : slots_cmp;
  assign cur_inc   = CW'(cur) + CW'(1);
  // a cursor left beyond a shrunk wrap is granted once, then restarts at zero
  assign cur_nxt   = (cur_inc >= wrap) ? '0 : HW'(cur_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        cursor_q[i] <= '0;
      end
    end else if (cur_adv) begin
      cursor_q[lv_idx] <= cur_nxt;
    end
  end

  // age of the oldest retired entry, wrap-safe
  logic [StampW-1:0] age;
  logic              too_young;

  assign age       = frame_q - ret_head.stamp;
  assign too_young = (age < StampW'(delay_q));

  // result register
  logic               out_valid_q;
  logic               out_free;
  logic               out_load;
  kind_e              kind_d, kind_q;
  logic [SlotW-1:0]   slot_d, slot_q;
  logic               from_ready_d, from_ready_q;
  logic [OffsetW-1:0] offset_d, offset_q;
  logic [CountW-1:0]  count_d, count_q;
  logic               last_d, last_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    frame_inc    = 1'b0;
    ret_push     = 1'b0;
    ret_rd       = 1'b0;
    ret_pop      = 1'b0;
    rdy_push     = 1'b0;
    rdy_rd       = 1'b0;
    rdy_pop      = 1'b0;
    cur_adv      = 1'b0;
    out_load     = 1'b0;
    kind_d       = KIND_GRANT;
    slot_d       = '0;
    from_ready_d = 1'b0;
    offset_d     = '0;
    count_d      = '0;
    last_d       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_opcode_i)
            OP_TICK:   frame_inc = 1'b1;
            OP_ALLOC:  state_d = ST_DRAIN_RD;
            OP_RETIRE: state_d = ST_RETIRE;
            default: ;
          endcase
        end
      end
      ST_RETIRE: begin
        if (out_free) begin
          out_load = 1'b1;
          slot_d   = ps_q;
          last_d   = 1'b1;
          if (lv_ok && !ret_stat.full) begin
            ret_push = 1'b1;
            kind_d   = KIND_RET_OK;
          end else begin
            kind_d   = KIND_RET_DROP;
          end
          state_d = ST_IDLE;
        end
      end
      ST_DRAIN_RD: begin
        if (!lv_ok) begin
          state_d = ST_GRANT;
        end else if (!ret_stat.empty && !rdy_stat.full) begin
          ret_rd  = 1'b1;
          state_d = ST_DRAIN_CHK;
        end else begin
          state_d = ST_GRANT_RD;
        end
      end
      ST_DRAIN_CHK: begin
        if (too_young) begin
          state_d = ST_GRANT_RD;
        end else if (ret_head.count == '0 || out_free) begin
          // entries without a range move silently
          out_load = (ret_head.count != '0);
          kind_d   = KIND_FREED;
          slot_d   = ret_head.slot;
          offset_d = ret_head.offset;
          count_d  = ret_head.count;
          rdy_push = 1'b1;
          ret_pop  = 1'b1;
          state_d  = ST_DRAIN_RD;
        end
      end
      ST_GRANT_RD: begin
        rdy_rd  = !rdy_stat.empty;
        state_d = ST_GRANT;
      end
      ST_GRANT: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_GRANT;
          last_d   = 1'b1;
          if (!lv_ok) begin
            slot_d = '0;
          end else if (!rdy_stat.empty) begin
            rdy_pop      = 1'b1;
            from_ready_d = 1'b1;
            slot_d       = rdy_head;
          end else begin
            cur_adv = 1'b1;
            slot_d  = cur_ext[SlotW-1:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q       <= kind_d;
      slot_q       <= slot_d;
      from_ready_q <= from_ready_d;
      offset_q     <= offset_d;
      count_q      <= count_d;
      last_q       <= last_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_kind_o         = kind_q;
  assign out_granted_slot_o = slot_q;
  assign out_from_ready_o   = from_ready_q;
  assign out_freed_offset_o = offset_q;
  assign out_freed_count_o  = count_q;
  assign out_last_o         = last_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ret_push |-> !ret_stat.full && lv_ok)
    else $error("retired queue written while full or for an unused level");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy_push |-> !rdy_stat.full && !ret_stat.empty && ret_pop)
    else $error("ready queue fill without a matching retired queue pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy_pop |-> !rdy_stat.empty && $past(rdy_rd || state_q == ST_GRANT))
    else $error("ready queue popped while empty or without a prior read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && last_d |=> state_q == ST_IDLE)
    else $error("final result of an item did not end the item");

endmodule

`default_nettype wire
